>>> src/gpr_pkg.sv
// ----------------------------------------------------------------------------
// gpr_pkg
// Shared types and codes for the GPIO controller with pin reservation.
// ----------------------------------------------------------------------------
`default_nettype none

package gpr_pkg;

  localparam int REQ_W         = 4;
  localparam int PORT_W        = 3;
  localparam int PIN_W         = 4;
  localparam int BYTE_W        = 8;
  localparam int STAT_W        = 3;
  localparam int PINS_PER_PORT = 8;

  typedef enum logic [REQ_W-1:0] {
    REQ_INIT     = 4'd0,
    REQ_RESERVE  = 4'd1,
    REQ_RELEASE  = 4'd2,
    REQ_PORT_DIR = 4'd3,
    REQ_PIN_DIR  = 4'd4,
    REQ_PORT_VAL = 4'd5,
    REQ_PIN_VAL  = 4'd6,
    REQ_TOGGLE   = 4'd7,
    REQ_READ_PIN = 4'd8
  } req_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK           = 3'd0,
    ST_NOT_INIT     = 3'd1,
    ST_INVALID      = 3'd2,
    ST_RESERVED     = 3'd3,
    ST_NOT_RESERVED = 3'd4
  } stat_t;

  typedef struct packed {
    logic [REQ_W-1:0]  req_type;
    logic [PORT_W-1:0] port;
    logic [PIN_W-1:0]  pin;
    logic [BYTE_W-1:0] byte_value;
    logic              bit_value;
    logic [BYTE_W-1:0] pad_byte;
  } item_t;

  typedef struct packed {
    stat_t             status;
    logic              read_bit;
    logic [BYTE_W-1:0] drive_byte;
    logic [BYTE_W-1:0] dir_byte;
  } result_t;

endpackage

`default_nettype wire

>>> src/gpr_if.sv
// ----------------------------------------------------------------------------
// gpr_if
// Valid/ready channels for request items and result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface gpr_in_if;
  logic       valid;
  logic       ready;
  logic [3:0] req_type;
  logic [2:0] port;
  logic [3:0] pin;
  logic [7:0] byte_value;
  logic       bit_value;
  logic [7:0] pad_byte;

  modport source (output valid, output req_type, output port, output pin,
                  output byte_value, output bit_value, output pad_byte,
                  input ready);
  modport sink   (input valid, input req_type, input port, input pin,
                  input byte_value, input bit_value, input pad_byte,
                  output ready);
endinterface

interface gpr_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic       read_bit;
  logic [7:0] drive_byte;
  logic [7:0] dir_byte;

  modport source (output valid, output status, output read_bit,
                  output drive_byte, output dir_byte, input ready);
  modport sink   (input valid, input status, input read_bit,
                  input drive_byte, input dir_byte, output ready);
endinterface

`default_nettype wire

>>> src/gpr_in_stage.sv
// ----------------------------------------------------------------------------
// gpr_in_stage
// Input register for request items.
// ----------------------------------------------------------------------------
`default_nettype none

module gpr_in_stage (
  input  wire logic          clk,
  input  wire logic          rst_n,
  gpr_in_if.sink             in_ch,
  input  wire logic          adv,
  output gpr_pkg::item_t     item,
  output logic               item_v
);
  import gpr_pkg::*;

  logic  in_v_r;
  logic  in_v_nxt;
  item_t in_pl_r;
  logic  take;

  // slot frees up when the held item moves on this cycle
  assign in_ch.ready = !in_v_r || adv;
  assign take        = in_ch.valid && in_ch.ready;
  assign in_v_nxt    = take ? 1'b1 : (adv ? 1'b0 : in_v_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else begin
      in_v_r <= in_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      in_pl_r.req_type   <= in_ch.req_type;
      in_pl_r.port       <= in_ch.port;
      in_pl_r.pin        <= in_ch.pin;
      in_pl_r.byte_value <= in_ch.byte_value;
      in_pl_r.bit_value  <= in_ch.bit_value;
      in_pl_r.pad_byte   <= in_ch.pad_byte;
    end
  end

  assign item   = in_pl_r;
  assign item_v = in_v_r;

endmodule

`default_nettype wire

>>> src/gpr_core.sv
// ----------------------------------------------------------------------------
// gpr_core
// Port state (reservation, direction, output) and the request decode.
// ----------------------------------------------------------------------------
`default_nettype none

module gpr_core #(
  parameter int NUM_PORTS = 7
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire gpr_pkg::item_t  item,
  input  wire logic            fire,
  output gpr_pkg::result_t     res
);
  import gpr_pkg::*;

  localparam int IDX_W = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;
  localparam logic [PORT_W:0] PORT_LIM = (PORT_W+1)'(NUM_PORTS);

  logic              ready_r;
  logic [BYTE_W-1:0] res_map_r [NUM_PORTS];
  logic [BYTE_W-1:0] dir_r     [NUM_PORTS];
  logic [BYTE_W-1:0] out_r     [NUM_PORTS];

  logic [IDX_W-1:0]  idx;
  logic              port_ok;
  logic              pin_ok;
  logic              pin_req;
  logic              init_go;
  logic [BYTE_W-1:0] mask;
  logic [BYTE_W-1:0] cur_res;
  logic [BYTE_W-1:0] cur_dir;
  logic [BYTE_W-1:0] cur_out;
  logic [BYTE_W-1:0] new_res;
  logic [BYTE_W-1:0] new_dir;
  logic [BYTE_W-1:0] new_out;
  stat_t             status;
  logic              rbit;

  assign idx     = item.port[IDX_W-1:0];
  assign port_ok = {1'b0, item.port} < PORT_LIM;
  assign pin_ok  = item.pin < PIN_W'(PINS_PER_PORT);
  assign mask    = pin_ok ? (BYTE_W'(1) << item.pin[2:0]) : '0;
  assign cur_res = port_ok ? res_map_r[idx] : '0;
  assign cur_dir = port_ok ? dir_r[idx]     : '0;
  assign cur_out = port_ok ? out_r[idx]     : '0;

  always_comb begin
    case (item.req_type) inside
      REQ_RESERVE, REQ_RELEASE, REQ_PIN_DIR, REQ_PIN_VAL, REQ_TOGGLE,
      REQ_READ_PIN: pin_req = 1'b1;
      default:      pin_req = 1'b0;
    endcase
  end

  always_comb begin
    new_res = cur_res;
    new_dir = cur_dir;
    new_out = cur_out;
    status  = ST_OK;
    rbit    = 1'b0;
    init_go = 1'b0;
    if (item.req_type > REQ_READ_PIN) begin
      status = ST_INVALID;
    end else if (item.req_type == REQ_INIT) begin
      // only the first init has any effect; direction is kept
      if (!ready_r) begin
        init_go = 1'b1;
        new_res = '0;
        new_out = '0;
      end
    end else if (!ready_r) begin
      status = ST_NOT_INIT;
    end else if (!port_ok || (pin_req && !pin_ok)) begin
      status = ST_INVALID;
    end else begin
      case (item.req_type)
        REQ_RESERVE: begin
          if ((cur_res & mask) != '0) status = ST_RESERVED;
          else                        new_res = cur_res | mask;
        end
        REQ_RELEASE: new_res = cur_res & ~mask;
        REQ_PORT_DIR, REQ_PORT_VAL: begin
          // whole-port write needs any pin of the port held
          if (cur_res == '0)                      status  = ST_NOT_RESERVED;
          else if (item.req_type == REQ_PORT_DIR) new_dir = item.byte_value;
          else                                    new_out = item.byte_value;
        end
        default: begin
          if ((cur_res & mask) == '0) begin
            status = ST_NOT_RESERVED;
          end else begin
            case (item.req_type)
              REQ_PIN_DIR:  new_dir = item.bit_value ? (cur_dir | mask)
                                                     : (cur_dir & ~mask);
              REQ_PIN_VAL:  new_out = item.bit_value ? (cur_out | mask)
                                                     : (cur_out & ~mask);
              REQ_TOGGLE:   new_out = cur_out ^ mask;
              default:      rbit    = |(item.pad_byte & mask);
            endcase
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ready_r <= 1'b0;
      for (int i = 0; i < NUM_PORTS; i++) begin
        res_map_r[i] <= '0;
        dir_r[i]     <= '0;
        out_r[i]     <= '0;
      end
    end else if (fire) begin
      if (init_go) begin
        ready_r <= 1'b1;
        for (int i = 0; i < NUM_PORTS; i++) begin
          res_map_r[i] <= '0;
          out_r[i]     <= '0;
        end
      end else if (port_ok) begin
        res_map_r[idx] <= new_res;
        dir_r[idx]     <= new_dir;
        out_r[idx]     <= new_out;
      end
    end
  end

  assign res.status     = status;
  assign res.read_bit   = rbit;
  assign res.drive_byte = new_out;
  assign res.dir_byte   = new_dir;

endmodule

`default_nettype wire

>>> src/gpr_out_stage.sv
// ----------------------------------------------------------------------------
// gpr_out_stage
// Result register driving the result channel.
// ----------------------------------------------------------------------------
`default_nettype none

module gpr_out_stage (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire gpr_pkg::result_t  res,
  input  wire logic              load,
  output logic                   can_load,
  gpr_out_if.source              out_ch
);
  import gpr_pkg::*;

  logic    out_v_r;
  logic    out_v_nxt;
  result_t res_r;

  assign can_load  = !out_v_r || out_ch.ready;
  assign out_v_nxt = load ? 1'b1 : (out_ch.ready ? 1'b0 : out_v_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else begin
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_ch.valid      = out_v_r;
  assign out_ch.status     = res_r.status;
  assign out_ch.read_bit   = res_r.read_bit;
  assign out_ch.drive_byte = res_r.drive_byte;
  assign out_ch.dir_byte   = res_r.dir_byte;

endmodule

`default_nettype wire

>>> src/gpio_controller_with_pin_reservation_top.sv
// ----------------------------------------------------------------------------
// gpio_controller_with_pin_reservation_top
// GPIO controller for NUM_PORTS 8-bit ports with a pin reservation map.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one request item (req_type, port, pin, byte_value,
//   bit_value, pad_byte); out_ch returns exactly one result item per
//   request (status, read_bit, drive_byte, dir_byte), in request order.
//   An item taken from in_ch waits in the input register; when it advances
//   it is decoded and applied to the port state, and its result is loaded
//   into the result register that drives out_ch.
//   Throughput is 1 item per cycle unless out_ch stalls: each request but
//   init is one read-modify-write of one port's bytes between the input
//   and result registers, so back-to-back requests see each other's updates.
//   Reset clears the ready flag and all reservation, direction and output
//   bytes; nothing but init succeeds until the first init request.
//   When out_ch stalls, the result register holds and one more item can
//   wait in the input register; after that in_ch.ready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module gpio_controller_with_pin_reservation_top #(
  parameter int NUM_PORTS = 7
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  gpr_in_if.sink      in_ch,
  gpr_out_if.source   out_ch
);
  import gpr_pkg::*;

  item_t   item;
  logic    item_v;
  logic    can_load;
  logic    adv;
  result_t res;

  assign adv = item_v && can_load;

  gpr_in_stage u_in (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .adv    (adv),
    .item   (item),
    .item_v (item_v)
  );

  gpr_core #(
    .NUM_PORTS (NUM_PORTS)
  ) u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .item  (item),
    .fire  (adv),
    .res   (res)
  );

  gpr_out_stage u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .res      (res),
    .load     (adv),
    .can_load (can_load),
    .out_ch   (out_ch)
  );

endmodule

`default_nettype wire
